// File: src/bc_pkg.sv
package bc_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_OUT    = 16;

    localparam int IN_W  = 16;
    localparam int OUT_W = 32;
    localparam int DW    = COORD_WIDTH + 1;
    localparam int PW    = 2 * DW;
    localparam int XW    = PW + 1;
    localparam int NWW   = XW + 2;
    localparam int MW    = NWW;
    localparam int QB    = 33;
    localparam int NSW   = MW + FRAC_OUT + 1;
    localparam int RW    = XW + 1;
    localparam int SW    = XW + OUT_W - FRAC_OUT;
    localparam int LANES = 3;
    localparam int FRONT_STAGES = 5;

    typedef struct packed {
        logic neg;
        logic sat;
        logic zero;
    } bc_tag_t;

    function automatic logic signed [DW-1:0] sext(input logic [IN_W-1:0] raw);
        logic [COORD_WIDTH+IN_W-1:0] z;
        logic signed [COORD_WIDTH-1:0] c;
        z = {{COORD_WIDTH{1'b0}}, raw};
        c = z[COORD_WIDTH-1:0];
        return DW'(c);
    endfunction

endpackage

// File: src/bc_if.sv
interface bc_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [bc_pkg::IN_W-1:0]         v0_x;
    logic signed [bc_pkg::IN_W-1:0]         v0_y;
    logic signed [bc_pkg::IN_W-1:0]         v1_x;
    logic signed [bc_pkg::IN_W-1:0]         v1_y;
    logic signed [bc_pkg::IN_W-1:0]         v2_x;
    logic signed [bc_pkg::IN_W-1:0]         v2_y;
    logic signed [bc_pkg::IN_W-1:0]         point_x;
    logic signed [bc_pkg::IN_W-1:0]         point_y;

    modport source (output valid, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, point_x, point_y,
                    input ready);
    modport sink   (input valid, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, point_x, point_y,
                    output ready);
endinterface

interface bc_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [bc_pkg::OUT_W-1:0]        weight_u;
    logic signed [bc_pkg::OUT_W-1:0]        weight_v;
    logic signed [bc_pkg::OUT_W-1:0]        weight_w;
    logic                                   degenerate;

    modport source (output valid, weight_u, weight_v, weight_w, degenerate, input ready);
    modport sink   (input valid, weight_u, weight_v, weight_w, degenerate, output ready);
endinterface

// File: src/bc_front.sv
// Edge vectors, cross products, magnitudes and saturation pre-check.
module bc_front (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      en,
    input  logic                                      in_valid,
    input  logic [7:0][bc_pkg::IN_W-1:0]              coords,
    output logic                                      out_valid,
    output logic [bc_pkg::LANES-1:0][bc_pkg::MW-1:0]  n_mag,
    output logic [bc_pkg::XW-1:0]                     d_mag,
    output bc_pkg::bc_tag_t [bc_pkg::LANES-1:0]       tag
);
    localparam int DW  = bc_pkg::DW;
    localparam int PW  = bc_pkg::PW;
    localparam int XW  = bc_pkg::XW;
    localparam int MW  = bc_pkg::MW;
    localparam int NWW = bc_pkg::NWW;
    localparam int SW  = bc_pkg::SW;
    localparam int SH  = bc_pkg::OUT_W - 1 - bc_pkg::FRAC_OUT;

    logic [bc_pkg::FRONT_STAGES-1:0] v_reg;

    // stage 1: edges
    logic signed [5:0][DW-1:0] e_reg;
    // stage 2: products
    logic signed [5:0][PW-1:0] p_reg;
    // stage 3: cross products
    logic signed [XW-1:0] den_reg, nu_reg, nv_reg;
    // stage 4: magnitudes
    logic [2:0][MW-1:0]   m4_reg;
    logic [XW-1:0]        d4_reg;
    logic [2:0]           s4_reg;
    logic                 z4_reg;
    // stage 5: saturation check
    logic [2:0][MW-1:0]   m5_reg;
    logic [XW-1:0]        d5_reg;
    bc_pkg::bc_tag_t [2:0] t5_reg;

    logic signed [DW-1:0]  ax, ay;
    logic signed [NWW-1:0] nw;
    logic signed [NWW-1:0] sv [3];
    logic signed [XW-1:0]  dabs;
    logic [SW-1:0]         dsat;

    always_comb
    begin
        ax = bc_pkg::sext(coords[0]);
        ay = bc_pkg::sext(coords[1]);
        nw = NWW'(den_reg) - NWW'(nu_reg) - NWW'(nv_reg);
        sv[0] = NWW'(nu_reg);
        sv[1] = NWW'(nv_reg);
        sv[2] = nw;
        dabs = den_reg[XW-1] ? -den_reg : den_reg;
        dsat = (SW'(d4_reg) << SH) + SW'(d4_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[bc_pkg::FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e_reg[2*k]   <= bc_pkg::sext(coords[2*k+2]) - ax;
                e_reg[2*k+1] <= bc_pkg::sext(coords[2*k+3]) - ay;
            end
            // edges: 0/1 = e0, 2/3 = e1, 4/5 = e2; elements of a packed array are unsigned
            p_reg[0] <= $signed(e_reg[0]) * $signed(e_reg[3]);
            p_reg[1] <= $signed(e_reg[1]) * $signed(e_reg[2]);
            p_reg[2] <= $signed(e_reg[4]) * $signed(e_reg[3]);
            p_reg[3] <= $signed(e_reg[5]) * $signed(e_reg[2]);
            p_reg[4] <= $signed(e_reg[0]) * $signed(e_reg[5]);
            p_reg[5] <= $signed(e_reg[1]) * $signed(e_reg[4]);
            den_reg  <= XW'($signed(p_reg[0])) - XW'($signed(p_reg[1]));
            nu_reg   <= XW'($signed(p_reg[2])) - XW'($signed(p_reg[3]));
            nv_reg   <= XW'($signed(p_reg[4])) - XW'($signed(p_reg[5]));
            for (int k = 0; k < 3; k++)
            begin
                m4_reg[k] <= MW'(sv[k][NWW-1] ? -sv[k] : sv[k]);
                s4_reg[k] <= sv[k][NWW-1] ^ den_reg[XW-1];
            end
            d4_reg <= XW'(dabs);
            z4_reg <= (den_reg == '0);
            for (int k = 0; k < 3; k++)
            begin
                m5_reg[k]      <= m4_reg[k];
                t5_reg[k].neg  <= s4_reg[k];
                t5_reg[k].sat  <= (SW'(m4_reg[k]) >= dsat);
                t5_reg[k].zero <= z4_reg;
            end
            d5_reg <= d4_reg;
        end
    end

    assign out_valid = v_reg[bc_pkg::FRONT_STAGES-1];
    assign n_mag     = m5_reg;
    assign d_mag     = d5_reg;
    assign tag       = t5_reg;
endmodule

// File: src/bc_div_lane.sv
// Restoring divider, one quotient bit per stage: q = floor(n * 2^(F+1) / d).
module bc_div_lane (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [bc_pkg::MW-1:0]     n_mag,
    input  logic [bc_pkg::XW-1:0]     d_mag,
    input  bc_pkg::bc_tag_t           in_tag,
    output logic                      out_valid,
    output logic [bc_pkg::QB-1:0]     quot,
    output bc_pkg::bc_tag_t           out_tag
);
    localparam int QB  = bc_pkg::QB;
    localparam int RW  = bc_pkg::RW;
    localparam int XW  = bc_pkg::XW;
    localparam int NSW = bc_pkg::NSW;

    logic [QB:0]                 v_reg;
    logic [RW-1:0]               r_reg [QB+1];
    logic [NSW-1:0]              n_reg [QB+1];
    logic [XW-1:0]               d_reg [QB+1];
    logic [QB-1:0]               q_reg [QB+1];
    bc_pkg::bc_tag_t             t_reg [QB+1];

    logic [NSW-1:0] nsh;
    assign nsh = NSW'(n_mag) << (bc_pkg::FRAC_OUT + 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[QB-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0] <= RW'(nsh >> QB);
            n_reg[0] <= nsh;
            d_reg[0] <= d_mag;
            q_reg[0] <= '0;
            t_reg[0] <= in_tag;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [RW:0] t;
        logic [RW:0] dx;
        logic        ge;
        always_comb
        begin
            t  = {r_reg[k], n_reg[k][QB-1-k]};
            dx = (RW+1)'(d_reg[k]);
            ge = (t >= dx);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k+1] <= ge ? RW'(t - dx) : RW'(t);
                n_reg[k+1] <= n_reg[k];
                d_reg[k+1] <= d_reg[k];
                q_reg[k+1] <= {q_reg[k][QB-2:0], ge};
                t_reg[k+1] <= t_reg[k];
            end
        end
    end

    assign out_valid = v_reg[QB];
    assign quot      = q_reg[QB];
    assign out_tag   = t_reg[QB];
endmodule

// File: src/barycentric_coords.sv
// Barycentric weights of a point in a 2D triangle, fully pipelined.
// Pipeline from input beat to result beat: 5 front stages, 34 divider stages
// (restoring divider per weight, sets depth), output register with rounding before it.
// Throughput: one beat per cycle while the result beat is not stalled.
// Reset: rst_n asynchronous active low clears all valid bits; data regs are not reset.
module barycentric_coords (
    input  logic      clk,
    input  logic      rst_n,
    bc_in_if.sink     pts,
    bc_out_if.source  res
);
    localparam int QB    = bc_pkg::QB;
    localparam int OUT_W = bc_pkg::OUT_W;
    localparam int LANES = bc_pkg::LANES;

    // whole pipeline moves together; it holds only when the output beat is stuck
    logic adv;
    assign adv       = !res.valid || res.ready;
    assign pts.ready = adv;

    logic [7:0][bc_pkg::IN_W-1:0] coords;
    assign coords = {pts.point_y, pts.point_x, pts.v2_y, pts.v2_x,
                     pts.v1_y, pts.v1_x, pts.v0_y, pts.v0_x};

    logic                                      f_valid;
    logic [LANES-1:0][bc_pkg::MW-1:0]          f_n;
    logic [bc_pkg::XW-1:0]                     f_d;
    bc_pkg::bc_tag_t [LANES-1:0]               f_tag;

    bc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (pts.valid),
        .coords    (coords),
        .out_valid (f_valid),
        .n_mag     (f_n),
        .d_mag     (f_d),
        .tag       (f_tag)
    );

    logic [LANES-1:0]           l_valid;
    logic [QB-1:0]              l_q   [LANES];
    bc_pkg::bc_tag_t            l_tag [LANES];
    logic signed [OUT_W-1:0]    wgt   [LANES];

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        bc_div_lane u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (f_valid),
            .n_mag     (f_n[i]),
            .d_mag     (f_d),
            .in_tag    (f_tag[i]),
            .out_valid (l_valid[i]),
            .quot      (l_q[i]),
            .out_tag   (l_tag[i])
        );

        // round half away from zero on magnitude, then sign and clamp
        logic [QB:0]   rnd;
        logic [QB-1:0] mag;
        always_comb
        begin
            rnd = {1'b0, l_q[i]} + (QB+1)'(1);
            mag = rnd[QB:1];
            if (l_tag[i].zero)
                wgt[i] = '0;
            else if (l_tag[i].neg)
            begin
                if (l_tag[i].sat || mag >= (QB'(1) << (OUT_W-1)))
                    wgt[i] = {1'b1, {(OUT_W-1){1'b0}}};
                else
                    wgt[i] = -$signed(mag[OUT_W-1:0]);
            end
            else
            begin
                if (l_tag[i].sat || mag > QB'({1'b0, {(OUT_W-1){1'b1}}}))
                    wgt[i] = {1'b0, {(OUT_W-1){1'b1}}};
                else
                    wgt[i] = $signed(mag[OUT_W-1:0]);
            end
        end
    end

    logic                    valid_reg;
    logic signed [OUT_W-1:0] u_reg, v_reg, w_reg;
    logic                    degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= l_valid[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u_reg     <= wgt[0];
            v_reg     <= wgt[1];
            w_reg     <= wgt[2];
            degen_reg <= l_tag[0].zero;
        end
    end

    assign res.valid      = valid_reg;
    assign res.weight_u   = u_reg;
    assign res.weight_v   = v_reg;
    assign res.weight_w   = w_reg;
    assign res.degenerate = degen_reg;

    // degenerate triangle gives all-zero weights
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.degenerate |->
            res.weight_u == '0 && res.weight_v == '0 && res.weight_w == '0)
        else $error("degenerate beat carries nonzero weights");

    // a stalled result beat stays put until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=>
            res.valid && $stable(res.weight_u) && $stable(res.weight_v) &&
            $stable(res.weight_w) && $stable(res.degenerate))
        else $error("result beat changed while stalled");

    // the three divider lanes stay in lockstep
    a_lanes_sync: assert property (@(posedge clk) disable iff (!rst_n)
        l_valid[0] == l_valid[1] && l_valid[0] == l_valid[2])
        else $error("divider lanes out of step");
endmodule

// File: verif/barycentric_coords_checker.sv
module barycentric_coords_checker (
    input  logic     clk,
    input  logic     rst_n,
    bc_in_if.sink    pts_mon,
    bc_out_if.sink   res_mon,
    output int       fail_count,
    output int       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] w;
        logic               degen;
    } weights_t;

    weights_t weight_fifo[$];

    function automatic longint to_coord(input logic [15:0] raw);
        logic signed [bc_pkg::COORD_WIDTH-1:0] c;
        c = raw[bc_pkg::COORD_WIDTH-1:0];
        return longint'(c);
    endfunction

    // round half away from zero, saturate to 32 bits
    function automatic logic signed [31:0] ratio_q(input longint num, input longint den);
        logic neg;
        longint unsigned n, d, q, r, mag;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = n / d;
        r = n % d;
        if (q > (64'd1 << (31 - bc_pkg::FRAC_OUT))) begin
            mag = 64'h8000_0001;
        end
        else begin
            mag = q;
            for (int i = 0; i < bc_pkg::FRAC_OUT; i++) begin
                r = r << 1;
                mag = mag << 1;
                if (r >= d) begin
                    r = r - d;
                    mag = mag | 1;
                end
            end
            r = r << 1;
            if (r >= d) mag = mag + 1;
        end
        if (neg) begin
            if (mag >= 64'h8000_0000) return 32'sh8000_0000;
            return -$signed(mag[31:0]);
        end
        if (mag > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
        return mag[31:0];
    endfunction

    function automatic weights_t solve_weights();
        weights_t e;
        longint ax, ay, e0x, e0y, e1x, e1y, e2x, e2y, den, nu, nv;
        ax = to_coord(pts_mon.v0_x);
        ay = to_coord(pts_mon.v0_y);
        e0x = to_coord(pts_mon.v1_x) - ax;
        e0y = to_coord(pts_mon.v1_y) - ay;
        e1x = to_coord(pts_mon.v2_x) - ax;
        e1y = to_coord(pts_mon.v2_y) - ay;
        e2x = to_coord(pts_mon.point_x) - ax;
        e2y = to_coord(pts_mon.point_y) - ay;
        den = e0x * e1y - e0y * e1x;
        nu = e2x * e1y - e2y * e1x;
        nv = e0x * e2y - e0y * e2x;
        if (den == 0) begin
            e.u = 0;
            e.v = 0;
            e.w = 0;
            e.degen = 1'b1;
        end
        else begin
            e.u = ratio_q(nu, den);
            e.v = ratio_q(nv, den);
            e.w = ratio_q(den - nu - nv, den);
            e.degen = 1'b0;
        end
        return e;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
        fail_count++;
    endtask

    initial fail_count = 0;
    initial pending = 0;

    always @(posedge clk) begin
        weights_t e;
        if (rst_n) begin
            if (res_mon.valid && res_mon.ready) begin
                if (weight_fifo.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end
                else begin
                    e = weight_fifo.pop_front();
                    if (res_mon.weight_u !== e.u) report_mismatch("weight_u", res_mon.weight_u, e.u);
                    if (res_mon.weight_v !== e.v) report_mismatch("weight_v", res_mon.weight_v, e.v);
                    if (res_mon.weight_w !== e.w) report_mismatch("weight_w", res_mon.weight_w, e.w);
                    if (res_mon.degenerate !== e.degen)
                        report_mismatch("degenerate", res_mon.degenerate, e.degen);
                end
            end
            if (pts_mon.valid && pts_mon.ready)
                weight_fifo.insert(weight_fifo.size(), solve_weights());
        end
        pending = weight_fifo.size();
    end

    task automatic report_leftover();
        if (weight_fifo.size() != 0) report_mismatch("results missing", 0, weight_fifo.size());
    endtask
endmodule

// File: verif/barycentric_coords_tb.sv
module barycentric_coords_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    bit   no_idle = 1'b0;     // set during the stretch with no idling on either side

    bc_in_if  pts ();
    bc_out_if res ();

    barycentric_coords dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pts   (pts.sink),
        .res   (res.source)
    );

    barycentric_coords_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .pts_mon    (pts.sink),
        .res_mon    (res.sink),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // run guard: about 1900 beats plus pipeline latency and random stalls
    // need well under 20k cycles; 200k leaves a wide margin
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > 200000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: ready drops with a chance of about 28 percent
    initial res.ready = 1'b0;
    always @(negedge clk) begin
        if (!rst_n) res.ready <= 1'b0;
        else res.ready <= no_idle || ($urandom_range(99) >= 28);
    end

    // extreme coordinates, picked often so corners and saturation get hit
    function automatic logic [15:0] pick_coord();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom_range(63)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // one input beat: valid held until accepted; optional idle cycles first
    task automatic send_beat(input logic [15:0] c[8]);
        if (!no_idle) begin
            while ($urandom_range(99) < 28) begin
                pts.valid <= 1'b0;
                @(negedge clk);
            end
        end
        pts.valid   <= 1'b1;
        pts.v0_x    <= c[0];
        pts.v0_y    <= c[1];
        pts.v1_x    <= c[2];
        pts.v1_y    <= c[3];
        pts.v2_x    <= c[4];
        pts.v2_y    <= c[5];
        pts.point_x <= c[6];
        pts.point_y <= c[7];
        @(posedge clk);
        while (!pts.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        pts.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial begin
        logic [15:0] c[8];
        logic [15:0] ax, ay, dx, dy;
        pts.valid = 1'b0;
        pts.v0_x = '0; pts.v0_y = '0; pts.v1_x = '0; pts.v1_y = '0;
        pts.v2_x = '0; pts.v2_y = '0; pts.point_x = '0; pts.point_y = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: right triangle with legs of 16, point at each vertex and inside
        c = '{16'd0, 16'd0, 16'd16, 16'd0, 16'd0, 16'd16, 16'd0, 16'd0};
        send_beat(c);
        c[6] = 16'd16; send_beat(c);
        c[6] = 16'd0; c[7] = 16'd16; send_beat(c);
        c[6] = 16'd5; c[7] = 16'd5; send_beat(c);
        // tie rounding: thirds and halves
        c[6] = 16'd8; c[7] = 16'd0; send_beat(c);
        c = '{16'd0, 16'd0, 16'd3, 16'd0, 16'd0, 16'd3, 16'd1, 16'd1};
        send_beat(c);
        // degenerate: coincident and collinear vertices
        c = '{16'd7, 16'd7, 16'd7, 16'd7, 16'd7, 16'd7, 16'd1, 16'd2};
        send_beat(c);
        c = '{16'd0, 16'd0, 16'd10, 16'd10, 16'd20, 16'd20, 16'd3, 16'd0};
        send_beat(c);
        // saturation: tiny triangle, far point (both signs)
        c = '{16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1, 16'h7FFF, 16'h7FFF};
        send_beat(c);
        c[6] = 16'h8000; c[7] = 16'h8000; send_beat(c);
        c[6] = 16'h7FFF; c[7] = 16'h8000; send_beat(c);
        // full-range extremes
        c = '{16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
              16'h7FFF, 16'h7FFF};
        send_beat(c);
        c = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
              16'h8000, 16'hFFFF};
        send_beat(c);
        c = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h7FFF,
              16'h8000, 16'h0001};
        send_beat(c);

        // pause until every expected result is back
        drain();

        for (int n = 0; n < 1900; n++) begin
            no_idle = (n >= 800 && n < 1000);
            case ($urandom_range(9))
                0, 1: begin
                    // fully random corners
                    foreach (c[k]) c[k] = pick_coord();
                end
                2: begin
                    // degenerate: vertex 2 on the line through v0, v1
                    foreach (c[k]) c[k] = 16'($urandom_range(4095)) - 16'd2048;
                    c[4] = c[0] + 16'd2 * (c[2] - c[0]);
                    c[5] = c[1] + 16'd2 * (c[3] - c[1]);
                end
                default: begin
                    // sane triangle, point near it, at random scale
                    ax = 16'($urandom); ay = 16'($urandom);
                    ax = {{4{ax[15]}}, ax[15:4]};
                    ay = {{4{ay[15]}}, ay[15:4]};
                    dx = 16'($urandom_range(511)) + 16'd1;
                    dy = 16'($urandom_range(511)) + 16'd1;
                    c[0] = ax; c[1] = ay;
                    c[2] = ax + dx; c[3] = ay + 16'($urandom_range(63)) - 16'd32;
                    c[4] = ax + 16'($urandom_range(63)) - 16'd32; c[5] = ay + dy;
                    c[6] = ax + 16'($urandom_range(1023)) - 16'd256;
                    c[7] = ay + 16'($urandom_range(1023)) - 16'd256;
                end
            endcase
            send_beat(c);
        end
        no_idle = 1'b0;

        drain();
        repeat (60) @(negedge clk);
        chk.report_leftover();
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// File: files.f
src/bc_pkg.sv
src/bc_if.sv
src/bc_front.sv
src/bc_div_lane.sv
src/barycentric_coords.sv
verif/barycentric_coords_checker.sv
verif/barycentric_coords_tb.sv
